### rtl/mexp_pkg.sv
package mexp_pkg;

	localparam int unsigned DATA_WIDTH = 32;
	localparam int unsigned CNT_WIDTH = $clog2(DATA_WIDTH);
	localparam int unsigned CFG_INDEX_WIDTH = 2;

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [DATA_WIDTH:0] wide_t;
	typedef logic [CNT_WIDTH-1:0] cnt_t;
	typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

	localparam cfg_index_t REG_EXPONENT = cfg_index_t'(0);
	localparam cfg_index_t REG_MODULUS = cfg_index_t'(1);

	localparam cnt_t LAST_STEP = cnt_t'(DATA_WIDTH - 1);

	typedef struct packed {
		logic start;
		word_t a;
		word_t b;
		word_t m;
	} mm_req_t;

	typedef struct packed {
		logic done;
		word_t product;
	} mm_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RED = 5'b00010,
		ST_MUL = 5'b00100,
		ST_SQR = 5'b01000,
		ST_OUT = 5'b10000
	} state_t;

endpackage

### rtl/modular_exponentiation_core.sv
// Modular exponentiation core: power_result = base_value ** exponent mod modulus.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
// exponent at index 0 and the modulus at index 1; other indexes are ignored. Both
// registers reset to one. Write them only while no item is in flight.
// An item enters on the input channel (in_valid, in_ready, base_value). The core
// then works on it alone and drops in_ready until the result is registered.
// All arithmetic runs on one shared shift-add modular multiplier that retires one
// multiplier bit per cycle. The base is first reduced by the modulus on that
// unit, then every exponent bit costs a square plus a multiply where the bit is
// set. With a modulus of zero or one the result is zero.
// The result waits in an output register on (out_valid, out_ready, power_result).
// A stalled receiver holds the result there; a following item may be accepted and
// computed, and its result is loaded once the held one has been taken.
// Reset (arst_n low) clears the sequencer and drops out_valid at once.
module modular_exponentiation_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input mexp_pkg::cfg_index_t cfg_index,
	input mexp_pkg::word_t cfg_data,
	input logic in_valid,
	output logic in_ready,
	input mexp_pkg::word_t base_value,
	output logic out_valid,
	input logic out_ready,
	output mexp_pkg::word_t power_result
);

	mexp_pkg::state_t state_q;
	mexp_pkg::word_t exponent_q;
	mexp_pkg::word_t modulus_q;
	mexp_pkg::word_t res_q;
	mexp_pkg::word_t pow_q;
	mexp_pkg::word_t out_q;
	mexp_pkg::cnt_t bit_q;
	logic out_valid_q;

	mexp_pkg::mm_req_t mm_req;
	mexp_pkg::mm_rsp_t mm_rsp;

	logic in_fire;
	logic small_mod;
	logic last_bit;
	logic out_free;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == mexp_pkg::ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign small_mod = (modulus_q[mexp_pkg::DATA_WIDTH-1:1] == '0);
	assign last_bit = (bit_q == mexp_pkg::LAST_STEP);
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign power_result = out_q;

	mexp_mulmod u_mulmod (
		.clk(clk),
		.arst_n(arst_n),
		.req(mm_req),
		.rsp(mm_rsp)
	);

	always_comb begin
		mm_req.start = 1'b0;
		mm_req.a = res_q;
		mm_req.b = pow_q;
		mm_req.m = modulus_q;
		unique case (state_q)
			mexp_pkg::ST_IDLE: begin
				if (in_fire && !small_mod) begin
					mm_req.start = 1'b1;
					mm_req.a = mexp_pkg::word_t'(1);
					mm_req.b = base_value;
				end
			end
			mexp_pkg::ST_RED: begin
				if (mm_rsp.done) begin
					mm_req.start = 1'b1;
					if (exponent_q[bit_q]) begin
						mm_req.a = res_q;
					end else begin
						mm_req.a = mm_rsp.product;
					end
					mm_req.b = mm_rsp.product;
				end
			end
			mexp_pkg::ST_MUL: begin
				if (mm_rsp.done) begin
					mm_req.start = 1'b1;
					mm_req.a = pow_q;
					mm_req.b = pow_q;
				end
			end
			mexp_pkg::ST_SQR: begin
				if (mm_rsp.done && !last_bit) begin
					mm_req.start = 1'b1;
					if (exponent_q[bit_q + mexp_pkg::cnt_t'(1)]) begin
						mm_req.a = res_q;
					end else begin
						mm_req.a = mm_rsp.product;
					end
					mm_req.b = mm_rsp.product;
				end
			end
			mexp_pkg::ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mexp_pkg::ST_IDLE;
			exponent_q <= mexp_pkg::word_t'(1);
			modulus_q <= mexp_pkg::word_t'(1);
			bit_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == mexp_pkg::REG_EXPONENT) begin
					exponent_q <= cfg_data;
				end else if (cfg_index == mexp_pkg::REG_MODULUS) begin
					modulus_q <= cfg_data;
				end
			end
			if ((state_q == mexp_pkg::ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				mexp_pkg::ST_IDLE: begin
					if (in_fire) begin
						bit_q <= '0;
						state_q <= small_mod ? mexp_pkg::ST_OUT : mexp_pkg::ST_RED;
					end
				end
				mexp_pkg::ST_RED: begin
					if (mm_rsp.done) begin
						state_q <= exponent_q[bit_q] ? mexp_pkg::ST_MUL : mexp_pkg::ST_SQR;
					end
				end
				mexp_pkg::ST_MUL: begin
					if (mm_rsp.done) begin
						state_q <= mexp_pkg::ST_SQR;
					end
				end
				mexp_pkg::ST_SQR: begin
					if (mm_rsp.done) begin
						if (last_bit) begin
							state_q <= mexp_pkg::ST_OUT;
						end else begin
							bit_q <= bit_q + mexp_pkg::cnt_t'(1);
							state_q <= exponent_q[bit_q + mexp_pkg::cnt_t'(1)]
								? mexp_pkg::ST_MUL : mexp_pkg::ST_SQR;
						end
					end
				end
				mexp_pkg::ST_OUT: begin
					if (out_free) begin
						state_q <= mexp_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= mexp_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			mexp_pkg::ST_IDLE: begin
				if (in_fire) begin
					res_q <= small_mod ? '0 : mexp_pkg::word_t'(1);
				end
			end
			mexp_pkg::ST_RED: begin
				if (mm_rsp.done) begin
					pow_q <= mm_rsp.product;
				end
			end
			mexp_pkg::ST_MUL: begin
				if (mm_rsp.done) begin
					res_q <= mm_rsp.product;
				end
			end
			mexp_pkg::ST_SQR: begin
				if (mm_rsp.done) begin
					pow_q <= mm_rsp.product;
				end
			end
			mexp_pkg::ST_OUT: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/mexp_mulmod.sv
module mexp_mulmod (
	input logic clk,
	input logic arst_n,
	input mexp_pkg::mm_req_t req,
	output mexp_pkg::mm_rsp_t rsp
);

	logic busy_q;
	logic done_q;
	mexp_pkg::cnt_t cnt_q;
	mexp_pkg::word_t acc_q;
	mexp_pkg::word_t a_q;
	mexp_pkg::word_t b_q;
	mexp_pkg::word_t m_q;

	mexp_pkg::wide_t dbl;
	mexp_pkg::wide_t m_wide;
	mexp_pkg::wide_t red1;
	mexp_pkg::wide_t sum;
	mexp_pkg::wide_t red2;
	mexp_pkg::word_t addend;

	always_comb begin
		m_wide = {1'b0, m_q};
		dbl = {acc_q, 1'b0};
		red1 = (dbl >= m_wide) ? (dbl - m_wide) : dbl;
		addend = b_q[mexp_pkg::DATA_WIDTH-1] ? a_q : '0;
		sum = {1'b0, red1[mexp_pkg::DATA_WIDTH-1:0]} + {1'b0, addend};
		red2 = (sum >= m_wide) ? (sum - m_wide) : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= mexp_pkg::LAST_STEP;
			end else if (busy_q) begin
				cnt_q <= cnt_q - mexp_pkg::cnt_t'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q <= req.a;
			b_q <= req.b;
			m_q <= req.m;
		end else if (busy_q) begin
			acc_q <= red2[mexp_pkg::DATA_WIDTH-1:0];
			b_q <= {b_q[mexp_pkg::DATA_WIDTH-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.product = acc_q;

endmodule

### test/modular_exponentiation_core_test.sv
module modular_exponentiation_core_test;

	import mexp_pkg::*;

	localparam cfg_index_t REG_UNUSED_2 = cfg_index_t'(2);
	localparam cfg_index_t REG_UNUSED_3 = cfg_index_t'(3);
	localparam int unsigned ITEM_TARGET = 280;
	localparam int unsigned WATCHDOG_LIMIT = 40000;
	localparam int unsigned LONG_HOLD = 6000;
	localparam int unsigned TAIL_CYCLES = 2200;
	localparam int unsigned DIRECTED_ROWS = 33;

	typedef enum bit {ROW_WRITE, ROW_BASE} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		cfg_index_t index;
		word_t value;
		bit typed;
		word_t power;
	} plan_row_t;

	localparam plan_row_t DIRECTED_PLAN [DIRECTED_ROWS] = '{
		'{ROW_BASE, REG_EXPONENT, 32'd5, 1'b1, 32'd0},
		'{ROW_BASE, REG_EXPONENT, 32'hFFFF_FFFF, 1'b1, 32'd0},
		'{ROW_WRITE, REG_MODULUS, 32'hFFFF_FFFF, 1'b0, 32'd0},
		'{ROW_BASE, REG_EXPONENT, 32'hFFFF_FFFF, 1'b1, 32'd0},
		'{ROW_BASE, REG_EXPONENT, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
		'{ROW_BASE, REG_EXPONENT, 32'd0, 1'b1, 32'd0},
		'{ROW_WRITE, REG_EXPONENT, 32'd0, 1'b0, 32'd0},
		'{ROW_BASE, REG_EXPONENT, 32'd0, 1'b1, 32'd1},
		'{ROW_BASE, REG_EXPONENT, 32'hFFFF_FFFF, 1'b1, 32'd1},
		'{ROW_WRITE, REG_EXPONENT, 32'hFFFF_FFFF, 1'b0, 32'd0},
		'{ROW_BASE, REG_EXPONENT, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
		'{ROW_BASE, REG_EXPONENT, 32'd2, 1'b0, 32'd0},
		'{ROW_BASE, REG_EXPONENT, 32'd1, 1'b1, 32'd1},
		'{ROW_WRITE, REG_MODULUS, 32'd0, 1'b0, 32'd0},
		'{ROW_BASE, REG_EXPONENT, 32'd7, 1'b1, 32'd0},
		'{ROW_WRITE, REG_MODULUS, 32'd1, 1'b0, 32'd0},
		'{ROW_WRITE, REG_EXPONENT, 32'd0, 1'b0, 32'd0},
		'{ROW_BASE, REG_EXPONENT, 32'd9, 1'b1, 32'd0},
		'{ROW_WRITE, REG_UNUSED_2, 32'd5, 1'b0, 32'd0},
		'{ROW_WRITE, REG_UNUSED_3, 32'd7, 1'b0, 32'd0},
		'{ROW_BASE, REG_EXPONENT, 32'd9, 1'b1, 32'd0},
		'{ROW_WRITE, REG_MODULUS, 32'h8000_0000, 1'b0, 32'd0},
		'{ROW_WRITE, REG_EXPONENT, 32'd3, 1'b0, 32'd0},
		'{ROW_BASE, REG_EXPONENT, 32'h1234_5679, 1'b0, 32'd0},
		'{ROW_BASE, REG_EXPONENT, 32'h8000_0000, 1'b1, 32'd0},
		'{ROW_WRITE, REG_MODULUS, 32'hFFFF_FFFB, 1'b0, 32'd0},
		'{ROW_WRITE, REG_EXPONENT, 32'hFFFF_FFF9, 1'b0, 32'd0},
		'{ROW_BASE, REG_EXPONENT, 32'd3, 1'b0, 32'd0},
		'{ROW_BASE, REG_EXPONENT, 32'hFFFF_FFFB, 1'b1, 32'd0},
		'{ROW_WRITE, REG_MODULUS, 32'd2, 1'b0, 32'd0},
		'{ROW_WRITE, REG_EXPONENT, 32'h8000_0000, 1'b0, 32'd0},
		'{ROW_BASE, REG_EXPONENT, 32'hFFFF_FFFF, 1'b1, 32'd1},
		'{ROW_BASE, REG_EXPONENT, 32'hFFFF_FFFE, 1'b1, 32'd0}
	};

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	cfg_index_t cfg_index;
	word_t cfg_data;
	logic in_valid;
	logic in_ready;
	word_t base_value;
	logic out_valid;
	logic out_ready;
	word_t power_result;

	word_t exponent_copy = word_t'(1);
	word_t modulus_copy = word_t'(1);
	word_t pending_powers [$];
	int unsigned items_sent = 0;
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;
	bit hold_off_request = 1'b0;

	modular_exponentiation_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.base_value(base_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.power_result(power_result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic word_t predict_power(word_t b, word_t e, word_t m);
		logic [63:0] acc;
		logic [63:0] sq;
		if (m <= 1) begin
			return '0;
		end
		acc = 64'd1;
		sq = 64'(b % m);
		for (int i = 0; i < DATA_WIDTH; i++) begin
			if (e[i]) begin
				acc = (acc * sq) % 64'(m);
			end
			sq = (sq * sq) % 64'(m);
		end
		return word_t'(acc);
	endfunction

	function automatic word_t pick_exponent();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return word_t'(1);
			2: return '1;
			3: return word_t'($urandom_range(2, 64));
			4: return word_t'(32'h8000_0000);
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic word_t pick_modulus();
		case ($urandom_range(0, 19))
			0: return word_t'(1);
			1: return word_t'(2);
			2: return '1;
			3, 4: return word_t'($urandom_range(3, 1000));
			5: return word_t'(32'h8000_0000);
			6: return '0;
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic word_t pick_base();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return word_t'(1);
			2: return modulus_copy - word_t'(1);
			3: return modulus_copy;
			4: return '1;
			5: return word_t'($urandom_range(0, 15));
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 4);
		end else if (r < 98) begin
			return $urandom_range(5, 60);
		end else begin
			return $urandom_range(200, 2500);
		end
	endfunction

	task automatic write_reg(input cfg_index_t idx, input word_t data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_EXPONENT: exponent_copy = data;
			REG_MODULUS: modulus_copy = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic offer_base(input word_t b, input int unsigned gap, input bit typed,
			input word_t power);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		base_value <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (typed) begin
			pending_powers.push_back(power);
		end else begin
			pending_powers.push_back(predict_power(b, exponent_copy, modulus_copy));
		end
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_powers.size() != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned stall;
		int unsigned calm_left;
		int unsigned r;
		calm_left = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				stall = LONG_HOLD;
			end else if (calm_left > 0) begin
				calm_left--;
				stall = 0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 6) begin
					calm_left = $urandom_range(5, 20);
					stall = 0;
				end else if (r < 60) begin
					stall = 0;
				end else if (r < 90) begin
					stall = $urandom_range(1, 5);
				end else if (r < 97) begin
					stall = $urandom_range(6, 80);
				end else begin
					stall = $urandom_range(300, 3000);
				end
			end
			if (stall > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		word_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_powers.size() == 0) begin
					$error("power_result: expected nothing, actual %h", power_result);
					error_count++;
				end else begin
					want = pending_powers.pop_front();
					if (power_result !== want) begin
						$error("power_result: expected %h, actual %h", want, power_result);
						error_count++;
					end
				end
			end
			if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("modular_exponentiation_core test failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned phase;
		int unsigned burst;
		bit steady;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_EXPONENT;
		cfg_data = '0;
		in_valid = 1'b0;
		base_value = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (DIRECTED_PLAN[i].kind == ROW_WRITE) begin
				drain();
				write_reg(DIRECTED_PLAN[i].index, DIRECTED_PLAN[i].value);
			end else begin
				offer_base(DIRECTED_PLAN[i].value, 0, DIRECTED_PLAN[i].typed,
					DIRECTED_PLAN[i].power);
			end
		end

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			drain();
			if ($urandom_range(0, 3) == 0) begin
				write_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
					word_t'($urandom));
			end
			write_reg(REG_EXPONENT, pick_exponent());
			write_reg(REG_MODULUS, pick_modulus());
			steady = ($urandom_range(0, 3) == 0);
			burst = $urandom_range(8, 30);
			if (phase == 2) begin
				hold_off_request = 1'b1;
				steady = 1'b1;
				burst = 8;
			end
			repeat (burst) begin
				offer_base(pick_base(), steady ? 0 : pick_gap(), 1'b0, '0);
			end
			phase++;
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_powers.size() == 0) begin
			$display("modular_exponentiation_core test passed");
		end else begin
			$display("modular_exponentiation_core test failed");
		end
		$finish;
	end

endmodule
